/* hdl/isap_pkg.sv */
// ----------------------------------------------------------------------------
// isap_pkg
// Shared types and constants of the shortest-augmenting-path max-flow engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package isap_pkg;

    localparam int DEFAULT_MAX_NODES = 1024;
    localparam int DEFAULT_MAX_EDGES = 8192;

    localparam int CAP_W    = 30;
    localparam int FLOW_W   = 32;
    localparam int RES_W    = 34;
    localparam int TOTAL_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [CAP_W-1:0] FLOW_CAP = 30'h3f3f3f3f;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_NODE  = 2'd2;

    typedef enum logic [4:0] {
        S_BOOT, S_IDLE, S_CLR,
        S_ADD_RF, S_ADD_WF, S_ADD_RT, S_ADD_WT,
        S_RUN_INIT, S_LOOP,
        S_ADV_E, S_ADV_T, S_ADV_D, S_ADV_C,
        S_REL_E, S_REL_T, S_REL_D, S_REL_C,
        S_REL_G1, S_REL_G2, S_REL_G3, S_REL_U,
        S_AUG_E, S_AUG_T, S_AUG_R, S_AUG_P,
        S_FIN, S_RESP
    } state_t;

    typedef struct packed {
        logic word;
        logic flow;
    } edge_we_t;

    typedef struct packed {
        logic head;
        logic label;
        logic cur;
        logic pred;
        logic gap;
    } node_we_t;

endpackage

`default_nettype wire

/* hdl/max_flow_isap_engine_top.sv */
// ----------------------------------------------------------------------------
// max_flow_isap_engine_top
// Max-flow engine (shortest augmenting paths with gap cut-off) on an edge
// table held in on-chip memories.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) takes one command transaction: clear
//   the graph, add a forward/reverse edge pair, or run max flow from
//   source_node to sink_node over node_count nodes. Every command returns
//   exactly one result transaction (flow_value, status) on the output channel.
//   One command is in flight at a time; in_ready is high only when idle.
//   Clear sweeps the list heads to null. A run first sweeps MAX_NODES + 1
//   entries of the per-node stores, then walks the graph: it scans arcs to
//   advance, relabels with a gap check, and augments along the predecessor
//   edges in two passes (bottleneck, then flow update). Add edge writes the
//   edge pair and list heads; rejected or unused commands go straight to the
//   result. Run time thus depends on graph shape.
//   After reset the list heads are swept to null before the first
//   transaction is taken.
//   The result sits in an output register; the next command is accepted
//   while it waits. A finished command stalls until that register frees up.
//   Flow stays on the edges after a run, so a later run continues from it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module max_flow_isap_engine_top
    import isap_pkg::*;
#(
    parameter int MAX_NODES = DEFAULT_MAX_NODES,
    parameter int MAX_EDGES = DEFAULT_MAX_EDGES
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           op,
    input  wire logic [9:0]           from_node,
    input  wire logic [9:0]           to_node,
    input  wire logic [CAP_W-1:0]     capacity,
    input  wire logic [CAP_W-1:0]     reverse_capacity,
    input  wire logic [9:0]           source_node,
    input  wire logic [9:0]           sink_node,
    input  wire logic [10:0]          node_count,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [TOTAL_W-1:0]        flow_value,
    output logic [STATUS_W-1:0]       status
);

    localparam int NW     = $clog2(MAX_NODES);
    localparam int LW     = $clog2(MAX_NODES + 1);
    localparam int EA     = $clog2(MAX_EDGES);
    localparam int EW     = EA + 1;          // edge pointer with a null code
    localparam int WORD_W = NW + EW + CAP_W; // {target, link, capacity}

    edge_we_t          edge_we;
    logic [EA-1:0]     edge_addr;
    logic [WORD_W-1:0] edge_wdata;
    logic [WORD_W-1:0] edge_rdata;
    logic [EA-2:0]     flow_addr;
    logic [FLOW_W-1:0] flow_wdata;
    logic [FLOW_W-1:0] flow_rdata;

    node_we_t          node_we;
    logic [NW-1:0]     head_addr;
    logic [EW-1:0]     head_wdata;
    logic [EW-1:0]     head_rdata;
    logic [NW-1:0]     dist_addr;
    logic [LW-1:0]     dist_wdata;
    logic [LW-1:0]     dist_rdata;
    logic [NW-1:0]     cur_addr;
    logic [EW-1:0]     cur_wdata;
    logic [EW-1:0]     cur_rdata;
    logic [NW-1:0]     pred_addr;
    logic [EW-1:0]     pred_wdata;
    logic [EW-1:0]     pred_rdata;
    logic [LW-1:0]     gap_addr;
    logic [LW-1:0]     gap_wdata;
    logic [LW-1:0]     gap_rdata;

    // sequencer: all address muxing and the result register live here
    isap_ctrl #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES),
        .EW        (EW),
        .WORD_W    (WORD_W)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .from_node        (from_node),
        .to_node          (to_node),
        .capacity         (capacity),
        .reverse_capacity (reverse_capacity),
        .source_node      (source_node),
        .sink_node        (sink_node),
        .node_count       (node_count),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .flow_value       (flow_value),
        .status           (status),
        .edge_we          (edge_we),
        .edge_addr        (edge_addr),
        .edge_wdata       (edge_wdata),
        .edge_rdata       (edge_rdata),
        .flow_addr        (flow_addr),
        .flow_wdata       (flow_wdata),
        .flow_rdata       (flow_rdata),
        .node_we          (node_we),
        .head_addr        (head_addr),
        .head_wdata       (head_wdata),
        .head_rdata       (head_rdata),
        .dist_addr        (dist_addr),
        .dist_wdata       (dist_wdata),
        .dist_rdata       (dist_rdata),
        .cur_addr         (cur_addr),
        .cur_wdata        (cur_wdata),
        .cur_rdata        (cur_rdata),
        .pred_addr        (pred_addr),
        .pred_wdata       (pred_wdata),
        .pred_rdata       (pred_rdata),
        .gap_addr         (gap_addr),
        .gap_wdata        (gap_wdata),
        .gap_rdata        (gap_rdata)
    );

    // edge table; flow kept once per pair, the odd edge reads it negated
    isap_edge_mem #(
        .MAX_EDGES (MAX_EDGES),
        .WORD_W    (WORD_W)
    ) u_edge_mem (
        .clk        (clk),
        .we         (edge_we),
        .edge_addr  (edge_addr),
        .edge_wdata (edge_wdata),
        .edge_rdata (edge_rdata),
        .flow_addr  (flow_addr),
        .flow_wdata (flow_wdata),
        .flow_rdata (flow_rdata)
    );

    isap_node_mem #(
        .MAX_NODES (MAX_NODES),
        .EW        (EW)
    ) u_node_mem (
        .clk        (clk),
        .we         (node_we),
        .head_addr  (head_addr),
        .head_wdata (head_wdata),
        .head_rdata (head_rdata),
        .dist_addr  (dist_addr),
        .dist_wdata (dist_wdata),
        .dist_rdata (dist_rdata),
        .cur_addr   (cur_addr),
        .cur_wdata  (cur_wdata),
        .cur_rdata  (cur_rdata),
        .pred_addr  (pred_addr),
        .pred_wdata (pred_wdata),
        .pred_rdata (pred_rdata),
        .gap_addr   (gap_addr),
        .gap_wdata  (gap_wdata),
        .gap_rdata  (gap_rdata)
    );

endmodule

`default_nettype wire

/* hdl/isap_edge_mem.sv */
// ----------------------------------------------------------------------------
// isap_edge_mem
// Edge table: {target, link, capacity} per edge, signed flow per edge pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isap_edge_mem
    import isap_pkg::*;
#(
    parameter int MAX_EDGES = DEFAULT_MAX_EDGES,
    parameter int WORD_W    = 54
)
(
    input  wire logic                          clk,
    input  wire edge_we_t                      we,
    input  wire logic [$clog2(MAX_EDGES)-1:0]  edge_addr,
    input  wire logic [WORD_W-1:0]             edge_wdata,
    output logic      [WORD_W-1:0]             edge_rdata,
    input  wire logic [$clog2(MAX_EDGES)-2:0]  flow_addr,
    input  wire logic [FLOW_W-1:0]             flow_wdata,
    output logic      [FLOW_W-1:0]             flow_rdata
);

    localparam int PAIRS = (MAX_EDGES + 1) / 2;

    logic [WORD_W-1:0] word_mem [MAX_EDGES];
    logic [FLOW_W-1:0] flow_mem [PAIRS];

    always_ff @(posedge clk)
    begin
        if (we.word)
        begin
            word_mem[edge_addr] <= edge_wdata;
        end
        edge_rdata <= word_mem[edge_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we.flow)
        begin
            flow_mem[flow_addr] <= flow_wdata;
        end
        flow_rdata <= flow_mem[flow_addr];
    end

endmodule

`default_nettype wire

/* hdl/isap_node_mem.sv */
// ----------------------------------------------------------------------------
// isap_node_mem
// Per-node stores: list head, distance label, current arc, predecessor edge,
// and the per-label gap counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isap_node_mem
    import isap_pkg::*;
#(
    parameter int MAX_NODES = DEFAULT_MAX_NODES,
    parameter int EW        = 14
)
(
    input  wire logic                            clk,
    input  wire node_we_t                        we,
    input  wire logic [$clog2(MAX_NODES)-1:0]    head_addr,
    input  wire logic [EW-1:0]                   head_wdata,
    output logic      [EW-1:0]                   head_rdata,
    input  wire logic [$clog2(MAX_NODES)-1:0]    dist_addr,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]  dist_wdata,
    output logic      [$clog2(MAX_NODES+1)-1:0]  dist_rdata,
    input  wire logic [$clog2(MAX_NODES)-1:0]    cur_addr,
    input  wire logic [EW-1:0]                   cur_wdata,
    output logic      [EW-1:0]                   cur_rdata,
    input  wire logic [$clog2(MAX_NODES)-1:0]    pred_addr,
    input  wire logic [EW-1:0]                   pred_wdata,
    output logic      [EW-1:0]                   pred_rdata,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]  gap_addr,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]  gap_wdata,
    output logic      [$clog2(MAX_NODES+1)-1:0]  gap_rdata
);

    localparam int LW = $clog2(MAX_NODES + 1);

    logic [EW-1:0] head_mem [MAX_NODES];
    logic [LW-1:0] dist_mem [MAX_NODES];
    logic [EW-1:0] cur_mem  [MAX_NODES];
    logic [EW-1:0] pred_mem [MAX_NODES];
    logic [LW-1:0] gap_mem  [MAX_NODES+1];

    always_ff @(posedge clk)
    begin
        if (we.head)
        begin
            head_mem[head_addr] <= head_wdata;
        end
        head_rdata <= head_mem[head_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we.label)
        begin
            dist_mem[dist_addr] <= dist_wdata;
        end
        dist_rdata <= dist_mem[dist_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we.cur)
        begin
            cur_mem[cur_addr] <= cur_wdata;
        end
        cur_rdata <= cur_mem[cur_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we.pred)
        begin
            pred_mem[pred_addr] <= pred_wdata;
        end
        pred_rdata <= pred_mem[pred_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we.gap)
        begin
            gap_mem[gap_addr] <= gap_wdata;
        end
        gap_rdata <= gap_mem[gap_addr];
    end

endmodule

`default_nettype wire

/* hdl/isap_ctrl.sv */
// ----------------------------------------------------------------------------
// isap_ctrl
// Sequencer: command decode, edge insertion, run sweep, advance / relabel /
// augment walks over the memories, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isap_ctrl
    import isap_pkg::*;
#(
    parameter int MAX_NODES = DEFAULT_MAX_NODES,
    parameter int MAX_EDGES = DEFAULT_MAX_EDGES,
    parameter int EW        = $clog2(MAX_EDGES) + 1,
    parameter int WORD_W    = $clog2(MAX_NODES) + EW + CAP_W
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      op,
    input  wire logic [9:0]                      from_node,
    input  wire logic [9:0]                      to_node,
    input  wire logic [CAP_W-1:0]                capacity,
    input  wire logic [CAP_W-1:0]                reverse_capacity,
    input  wire logic [9:0]                      source_node,
    input  wire logic [9:0]                      sink_node,
    input  wire logic [10:0]                     node_count,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [TOTAL_W-1:0]              flow_value,
    output logic      [STATUS_W-1:0]             status,
    output edge_we_t                             edge_we,
    output logic      [$clog2(MAX_EDGES)-1:0]    edge_addr,
    output logic      [WORD_W-1:0]               edge_wdata,
    input  wire logic [WORD_W-1:0]               edge_rdata,
    output logic      [$clog2(MAX_EDGES)-2:0]    flow_addr,
    output logic      [FLOW_W-1:0]               flow_wdata,
    input  wire logic [FLOW_W-1:0]               flow_rdata,
    output node_we_t                             node_we,
    output logic      [$clog2(MAX_NODES)-1:0]    head_addr,
    output logic      [EW-1:0]                   head_wdata,
    input  wire logic [EW-1:0]                   head_rdata,
    output logic      [$clog2(MAX_NODES)-1:0]    dist_addr,
    output logic      [$clog2(MAX_NODES+1)-1:0]  dist_wdata,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]  dist_rdata,
    output logic      [$clog2(MAX_NODES)-1:0]    cur_addr,
    output logic      [EW-1:0]                   cur_wdata,
    input  wire logic [EW-1:0]                   cur_rdata,
    output logic      [$clog2(MAX_NODES)-1:0]    pred_addr,
    output logic      [EW-1:0]                   pred_wdata,
    input  wire logic [EW-1:0]                   pred_rdata,
    output logic      [$clog2(MAX_NODES+1)-1:0]  gap_addr,
    output logic      [$clog2(MAX_NODES+1)-1:0]  gap_wdata,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]  gap_rdata
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int LW = $clog2(MAX_NODES + 1);
    localparam int EA = $clog2(MAX_EDGES);
    localparam int PA = EA - 1;
    localparam logic [EW-1:0] NIL      = '1;
    localparam logic [EW-1:0] EDGE_LIM = EW'(MAX_EDGES);
    localparam logic [LW-1:0] NODE_LIM = LW'(MAX_NODES);

    state_t state_reg, state_next;

    logic [LW-1:0]       idx_reg, idx_next;
    logic [1:0]          op_reg, op_next;
    logic [NW-1:0]       from_reg, from_next;
    logic [NW-1:0]       to_reg, to_next;
    logic [CAP_W-1:0]    cap_reg, cap_next;
    logic [CAP_W-1:0]    rcap_reg, rcap_next;
    logic [NW-1:0]       src_reg, src_next;
    logic [NW-1:0]       dst_reg, dst_next;
    logic [LW-1:0]       n_reg, n_next;
    logic [EW-1:0]       cnt_reg, cnt_next;
    logic [NW-1:0]       u_reg, u_next;
    logic [EW-1:0]       e_reg, e_next;
    logic [LW-1:0]       du_reg, du_next;
    logic [LW-1:0]       dsrc_reg, dsrc_next;
    logic [LW-1:0]       m_reg, m_next;
    logic [LW-1:0]       d_reg, d_next;
    logic [NW-1:0]       v_reg, v_next;
    logic [EW-1:0]       link_reg, link_next;
    logic signed [RES_W-1:0] res_reg, res_next;
    logic [FLOW_W-1:0]   fraw_reg, fraw_next;
    logic [CAP_W-1:0]    amt_reg, amt_next;
    logic                pass_reg, pass_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [TOTAL_W-1:0]  wflow_reg, wflow_next;   // result of the command in work
    logic [STATUS_W-1:0] wstat_reg, wstat_next;
    logic [TOTAL_W-1:0]  rflow_reg, rflow_next;
    logic [STATUS_W-1:0] rstat_reg, rstat_next;
    logic                ovalid_reg, ovalid_next;

    // read-side decode of the edge word
    logic [NW-1:0]           q_target;
    logic [EW-1:0]           q_link;
    logic [CAP_W-1:0]        q_cap;
    logic [FLOW_W-1:0]       q_flow;
    logic signed [RES_W-1:0] q_res;
    logic [EA-1:0]           e_mate;
    logic [EA-1:0]           p_mate;
    logic [LW:0]             m_inc;
    logic [LW-1:0]           g_dec;
    logic [TOTAL_W:0]        total_sum;
    logic                    run_bad;
    logic                    add_bad;

    assign q_target = edge_rdata[WORD_W-1 -: NW];
    assign q_link   = edge_rdata[EW+CAP_W-1 -: EW];
    assign q_cap    = edge_rdata[CAP_W-1:0];
    // odd edges carry the negated pair flow
    assign q_flow   = e_reg[0] ? (FLOW_W'(0) - flow_rdata) : flow_rdata;
    assign q_res    = $signed({{(RES_W-CAP_W){1'b0}}, q_cap})
                    - $signed({{(RES_W-FLOW_W){q_flow[FLOW_W-1]}}, q_flow});
    assign e_mate   = e_reg[EA-1:0] ^ EA'(1);
    assign p_mate   = pred_rdata[EA-1:0] ^ EA'(1);
    assign m_inc    = {1'b0, m_reg} + (LW+1)'(1);
    assign g_dec    = gap_rdata - LW'(1);
    assign total_sum = {1'b0, total_reg} + (TOTAL_W+1)'(amt_reg);

    assign run_bad = (node_count == 11'd0) || (32'(node_count) > MAX_NODES)
                   || ({1'b0, source_node} >= node_count)
                   || ({1'b0, sink_node} >= node_count)
                   || (source_node == sink_node);
    assign add_bad = (32'(from_node) >= MAX_NODES) || (32'(to_node) >= MAX_NODES);

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = ovalid_reg;
    assign flow_value = rflow_reg;
    assign status     = rstat_reg;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        op_next     = op_reg;
        from_next   = from_reg;
        to_next     = to_reg;
        cap_next    = cap_reg;
        rcap_next   = rcap_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        n_next      = n_reg;
        cnt_next    = cnt_reg;
        u_next      = u_reg;
        e_next      = e_reg;
        du_next     = du_reg;
        dsrc_next   = dsrc_reg;
        m_next      = m_reg;
        d_next      = d_reg;
        v_next      = v_reg;
        link_next   = link_reg;
        res_next    = res_reg;
        fraw_next   = fraw_reg;
        amt_next    = amt_reg;
        pass_next   = pass_reg;
        total_next  = total_reg;
        wflow_next  = wflow_reg;
        wstat_next  = wstat_reg;
        rflow_next  = rflow_reg;
        rstat_next  = rstat_reg;
        ovalid_next = ovalid_reg;

        edge_we    = '0;
        edge_addr  = e_reg[EA-1:0];
        edge_wdata = '0;
        flow_addr  = e_reg[EA-1:1];
        flow_wdata = '0;
        node_we    = '0;
        head_addr  = u_reg;
        head_wdata = NIL;
        dist_addr  = u_reg;
        dist_wdata = '0;
        cur_addr   = u_reg;
        cur_wdata  = e_reg;
        pred_addr  = u_reg;
        pred_wdata = e_reg;
        gap_addr   = du_reg;
        gap_wdata  = '0;

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_BOOT, S_CLR:
            begin
                node_we.head = 1'b1;
                head_addr    = idx_reg[NW-1:0];
                cnt_next     = '0;
                idx_next     = idx_reg + LW'(1);
                if (idx_reg == NODE_LIM - LW'(1))
                begin
                    idx_next   = '0;
                    state_next = (state_reg == S_BOOT) ? S_IDLE : S_RESP;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    from_next  = NW'(from_node);
                    to_next    = NW'(to_node);
                    cap_next   = capacity;
                    rcap_next  = reverse_capacity;
                    src_next   = NW'(source_node);
                    dst_next   = NW'(sink_node);
                    n_next     = LW'(node_count);
                    wflow_next = '0;
                    wstat_next = ST_OK;
                    idx_next   = '0;
                    unique case (op)
                        OP_CLEAR: state_next = S_CLR;
                        OP_ADD:
                        begin
                            if (add_bad)
                            begin
                                wstat_next = ST_BAD_NODE;
                                state_next = S_RESP;
                            end
                            else if (32'(cnt_reg) + 2 > MAX_EDGES)
                            begin
                                wstat_next = ST_FULL;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_ADD_RF;
                            end
                        end
                        OP_RUN:
                        begin
                            if (run_bad)
                            begin
                                wstat_next = ST_BAD_NODE;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_RUN_INIT;
                            end
                        end
                        default: state_next = S_RESP;
                    endcase
                end
            end

            S_ADD_RF:
            begin
                head_addr  = from_reg;
                state_next = S_ADD_WF;
            end

            S_ADD_WF:
            begin
                edge_we.word = 1'b1;
                edge_we.flow = 1'b1;
                edge_addr    = cnt_reg[EA-1:0];
                edge_wdata   = {to_reg, head_rdata, cap_reg};
                flow_addr    = cnt_reg[EA-1:1];
                node_we.head = 1'b1;
                head_addr    = from_reg;
                head_wdata   = cnt_reg;
                state_next   = S_ADD_RT;
            end

            S_ADD_RT:
            begin
                head_addr  = to_reg;
                state_next = S_ADD_WT;
            end

            S_ADD_WT:
            begin
                edge_we.word = 1'b1;
                edge_addr    = cnt_reg[EA-1:0] + EA'(1);
                edge_wdata   = {from_reg, head_rdata, rcap_reg};
                node_we.head = 1'b1;
                head_addr    = to_reg;
                head_wdata   = cnt_reg + EW'(1);
                cnt_next     = cnt_reg + EW'(2);
                state_next   = S_RESP;
            end

            // clear labels and gaps, copy heads into current arcs in the cycle after their read
            S_RUN_INIT:
            begin
                head_addr   = idx_reg[NW-1:0];
                node_we.gap = 1'b1;
                gap_addr    = idx_reg;
                gap_wdata   = (idx_reg == '0) ? n_reg : '0;
                node_we.label = (idx_reg != NODE_LIM);
                dist_addr   = idx_reg[NW-1:0];
                node_we.cur = (idx_reg != '0);
                cur_addr    = NW'(idx_reg - LW'(1));
                cur_wdata   = head_rdata;
                node_we.pred = (idx_reg == '0);
                pred_addr   = src_reg;
                pred_wdata  = NIL;
                idx_next    = idx_reg + LW'(1);
                if (idx_reg == NODE_LIM)
                begin
                    idx_next   = '0;
                    u_next     = src_reg;
                    dsrc_next  = '0;
                    total_next = '0;
                    state_next = S_LOOP;
                end
            end

            S_LOOP:
            begin
                if (dsrc_reg >= n_reg)
                begin
                    state_next = S_FIN;
                end
                else if (u_reg == dst_reg)
                begin
                    pred_addr  = dst_reg;
                    amt_next   = FLOW_CAP;
                    pass_next  = 1'b0;
                    state_next = S_AUG_E;
                end
                else
                begin
                    cur_addr   = u_reg;
                    dist_addr  = u_reg;
                    state_next = S_ADV_E;
                end
            end

            S_ADV_E:
            begin
                e_next     = cur_rdata;
                du_next    = dist_rdata;
                state_next = S_ADV_T;
            end

            S_ADV_T:
            begin
                if (e_reg >= EDGE_LIM)
                begin
                    head_addr  = u_reg;
                    state_next = S_REL_E;
                end
                else
                begin
                    state_next = S_ADV_D;
                end
            end

            S_ADV_D:
            begin
                v_next     = q_target;
                link_next  = q_link;
                res_next   = q_res;
                dist_addr  = q_target;
                state_next = S_ADV_C;
            end

            S_ADV_C:
            begin
                if ((res_reg != '0)
                    && ((LW+1)'(dist_rdata) + (LW+1)'(1) == (LW+1)'(du_reg)))
                begin
                    node_we.cur  = 1'b1;
                    cur_addr     = u_reg;
                    node_we.pred = 1'b1;
                    pred_addr    = v_reg;
                    u_next       = v_reg;
                    state_next   = S_LOOP;
                end
                else
                begin
                    e_next     = link_reg;
                    state_next = S_ADV_T;
                end
            end

            S_REL_E:
            begin
                e_next     = head_rdata;
                m_next     = n_reg;
                state_next = S_REL_T;
            end

            S_REL_T:
            begin
                if (e_reg >= EDGE_LIM)
                begin
                    gap_addr   = du_reg;
                    state_next = S_REL_G1;
                end
                else
                begin
                    state_next = S_REL_D;
                end
            end

            S_REL_D:
            begin
                v_next     = q_target;
                link_next  = q_link;
                res_next   = q_res;
                dist_addr  = q_target;
                state_next = S_REL_C;
            end

            S_REL_C:
            begin
                if ((res_reg != '0) && (dist_rdata < m_reg))
                begin
                    m_next      = dist_rdata;
                    node_we.cur = 1'b1;
                    cur_addr    = u_reg;
                end
                e_next     = link_reg;
                state_next = S_REL_T;
            end

            S_REL_G1:
            begin
                node_we.gap = 1'b1;
                gap_addr    = du_reg;
                gap_wdata   = g_dec;
                d_next      = (m_inc > (LW+1)'(n_reg)) ? n_reg : m_inc[LW-1:0];
                state_next  = (g_dec == '0) ? S_FIN : S_REL_G2;
            end

            S_REL_G2:
            begin
                node_we.label = 1'b1;
                dist_addr    = u_reg;
                dist_wdata   = d_reg;
                if (u_reg == src_reg)
                begin
                    dsrc_next = d_reg;
                end
                gap_addr   = d_reg;
                pred_addr  = u_reg;
                state_next = S_REL_G3;
            end

            S_REL_G3:
            begin
                node_we.gap = 1'b1;
                gap_addr    = d_reg;
                gap_wdata   = gap_rdata + LW'(1);
                if ((u_reg != src_reg) && (pred_rdata < EDGE_LIM))
                begin
                    edge_addr  = p_mate;
                    state_next = S_REL_U;
                end
                else
                begin
                    state_next = S_LOOP;
                end
            end

            S_REL_U:
            begin
                u_next     = q_target;
                state_next = S_LOOP;
            end

            S_AUG_E:
            begin
                e_next     = pred_rdata;
                state_next = S_AUG_T;
            end

            S_AUG_T:
            begin
                if (e_reg >= EDGE_LIM)
                begin
                    if (!pass_reg)
                    begin
                        pass_next  = 1'b1;
                        pred_addr  = dst_reg;
                        state_next = S_AUG_E;
                    end
                    else
                    begin
                        total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                        u_next     = src_reg;
                        state_next = S_LOOP;
                    end
                end
                else
                begin
                    state_next = S_AUG_R;
                end
            end

            S_AUG_R:
            begin
                res_next   = q_res;
                fraw_next  = flow_rdata;
                edge_addr  = e_mate;
                state_next = S_AUG_P;
            end

            S_AUG_P:
            begin
                if (!pass_reg)
                begin
                    if (res_reg < $signed({{(RES_W-CAP_W){1'b0}}, amt_reg}))
                    begin
                        amt_next = res_reg[CAP_W-1:0];
                    end
                end
                else
                begin
                    edge_we.flow = 1'b1;
                    flow_wdata   = e_reg[0] ? (fraw_reg - FLOW_W'(amt_reg))
                                            : (fraw_reg + FLOW_W'(amt_reg));
                end
                pred_addr  = q_target;
                state_next = S_AUG_E;
            end

            S_FIN:
            begin
                wflow_next = total_reg;
                state_next = S_RESP;
            end

            // hand the result to the output register once it is free
            S_RESP:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    rflow_next  = wflow_reg;
                    rstat_next  = wstat_reg;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_BOOT;
            idx_reg    <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
            dsrc_reg   <= '0;
            n_reg      <= '0;
            pass_reg   <= 1'b0;
            wflow_reg  <= '0;
            wstat_reg  <= ST_OK;
            rflow_reg  <= '0;
            rstat_reg  <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
            dsrc_reg   <= dsrc_next;
            n_reg      <= n_next;
            pass_reg   <= pass_next;
            wflow_reg  <= wflow_next;
            wstat_reg  <= wstat_next;
            rflow_reg  <= rflow_next;
            rstat_reg  <= rstat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        from_reg  <= from_next;
        to_reg    <= to_next;
        cap_reg   <= cap_next;
        rcap_reg  <= rcap_next;
        src_reg   <= src_next;
        dst_reg   <= dst_next;
        u_reg     <= u_next;
        e_reg     <= e_next;
        du_reg    <= du_next;
        m_reg     <= m_next;
        d_reg     <= d_next;
        v_reg     <= v_next;
        link_reg  <= link_next;
        res_reg   <= res_next;
        fraw_reg  <= fraw_next;
        amt_reg   <= amt_next;
        total_reg <= total_next;
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= MAX_EDGES)
        else $error("edge count beyond table size");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && rstat_reg != ST_OK) |-> (rflow_reg == '0))
        else $error("error result carries flow");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while busy");

    a_src_label: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOP) |-> (dsrc_reg <= n_reg))
        else $error("source label above node count");
`endif

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for max_flow_isap_engine_top: graph commands go through
// the input channel, and a flow predictor inside a scoreboard class checks
// every result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import isap_pkg::*;

    localparam int NODES       = 1024;
    localparam int EDGES       = 8192;
    localparam int CYCLE_LIMIT = 30_000_000;
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Scoreboard: carries its own copy of the graph and predicts each result.
    class flow_scoreboard;
        int unsigned edge_to [EDGES];
        int unsigned edge_nxt[EDGES];
        int unsigned edge_cap[EDGES];
        longint      edge_flw[EDGES];
        int unsigned head    [NODES];
        int unsigned n_edges;
        int unsigned gap_cnt [NODES+1];
        int unsigned dlabel  [NODES];
        int unsigned pred    [NODES];
        int unsigned arc     [NODES];
        logic [TOTAL_W-1:0]  flow_q[$];
        logic [STATUS_W-1:0] status_q[$];
        int errors;

        function new();
            errors = 0;
            n_edges = 0;
            foreach (head[i]) head[i] = 32'hFFFF_FFFF;
        endfunction

        function longint resid(int unsigned e);
            return longint'(edge_cap[e]) - edge_flw[e];
        endfunction

        function void add_arc(int unsigned a, int unsigned b, int unsigned c);
            edge_to[n_edges]  = b;
            edge_cap[n_edges] = c;
            edge_flw[n_edges] = 0;
            edge_nxt[n_edges] = head[a];
            head[a] = n_edges;
            n_edges++;
        endfunction

        // shortest augmenting paths with the gap cut-off
        function longint unsigned max_flow(int unsigned s, int unsigned t, int unsigned n);
            longint unsigned total;
            longint amt;
            int unsigned u, e, v, m, d;
            bit found;
            total = 0;
            u = s;
            v = 0;
            foreach (gap_cnt[i]) gap_cnt[i] = 0;
            foreach (dlabel[i]) dlabel[i] = 0;
            foreach (arc[i]) arc[i] = head[i];
            pred[s] = 32'hFFFF_FFFF;
            gap_cnt[0] = n & 11'h7FF;
            while (dlabel[s] < n) begin
                if (u == t) begin
                    amt = 64'h3f3f3f3f;
                    for (e = pred[t]; e < EDGES; e = pred[edge_to[e ^ 1]])
                        if (resid(e) < amt) amt = resid(e);
                    for (e = pred[t]; e < EDGES; e = pred[edge_to[e ^ 1]])
                    begin
                        edge_flw[e] += amt;
                        edge_flw[e ^ 1] -= amt;
                    end
                    total += longint'(amt);
                    u = s;
                    continue;
                end
                found = 0;
                for (e = arc[u]; e < EDGES; e = edge_nxt[e])
                begin
                    v = edge_to[e];
                    if (resid(e) != 0 && dlabel[v] + 1 == dlabel[u])
                    begin
                        found = 1;
                        arc[u] = e;
                        pred[v] = e;
                        break;
                    end
                end
                if (found)
                begin
                    u = v;
                    continue;
                end
                m = n;
                for (e = head[u]; e < EDGES; e = edge_nxt[e])
                    if (resid(e) != 0 && dlabel[edge_to[e]] < m)
                    begin
                        m = dlabel[edge_to[e]];
                        arc[u] = e;
                    end
                d = dlabel[u];
                gap_cnt[d] = (gap_cnt[d] - 1) & 11'h7FF;
                if (gap_cnt[d] == 0) return total;
                d = m + 1;
                if (d > n) d = n;
                dlabel[u] = d;
                gap_cnt[d] = (gap_cnt[d] + 1) & 11'h7FF;
                if (u != s && pred[u] < EDGES) u = edge_to[pred[u] ^ 1];
            end
            return total;
        endfunction

        // note an accepted command transaction and queue its result
        function void note_command(logic [1:0] o, logic [9:0] f, logic [9:0] t,
                                   logic [CAP_W-1:0] c, logic [CAP_W-1:0] rc,
                                   logic [9:0] s, logic [9:0] k, logic [10:0] n);
            longint unsigned fl;
            logic [STATUS_W-1:0] st;
            fl = 0;
            st = ST_OK;
            if (o == OP_CLEAR)
            begin
                n_edges = 0;
                foreach (head[i]) head[i] = 32'hFFFF_FFFF;
            end
            else if (o == OP_ADD)
            begin
                if (n_edges + 2 > EDGES) st = ST_FULL;
                else
                begin
                    add_arc(f, t, c);
                    add_arc(t, f, rc);
                end
            end
            else if (o == OP_RUN)
            begin
                if (n == 0 || n > NODES || s >= n || k >= n || s == k) st = ST_BAD_NODE;
                else
                begin
                    fl = max_flow(s, k, n);
                    if (fl > 64'hFFFF_FFFF) fl = 64'hFFFF_FFFF;
                end
            end
            flow_q.push_back(fl[31:0]);
            status_q.push_back(st);
        endfunction

        function void check_result(logic [TOTAL_W-1:0] fl, logic [STATUS_W-1:0] st);
            logic [TOTAL_W-1:0] ef;
            logic [STATUS_W-1:0] es;
            if (flow_q.size() == 0)
            begin
                $error("unexpected result: flow_value %0d status %0d", fl, st);
                errors++;
                return;
            end
            ef = flow_q.pop_front();
            es = status_q.pop_front();
            if (fl !== ef)
            begin
                $error("flow_value: expected %0d, actual %0d", ef, fl);
                errors++;
            end
            if (st !== es)
            begin
                $error("status: expected %0d, actual %0d", es, st);
                errors++;
            end
        endfunction

        function int pending();
            return flow_q.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [1:0]          op = '0;
    logic [9:0]          from_node = '0;
    logic [9:0]          to_node = '0;
    logic [CAP_W-1:0]    capacity = '0;
    logic [CAP_W-1:0]    reverse_capacity = '0;
    logic [9:0]          source_node = '0;
    logic [9:0]          sink_node = '0;
    logic [10:0]         node_count = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [TOTAL_W-1:0]  flow_value;
    logic [STATUS_W-1:0] status;

    flow_scoreboard sb = new();
    bit  steady = 1'b0;   // when set, neither side idles
    int  cycles = 0;

    max_flow_isap_engine_top i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .from_node        (from_node),
        .to_node          (to_node),
        .capacity         (capacity),
        .reverse_capacity (reverse_capacity),
        .source_node      (source_node),
        .sink_node        (sink_node),
        .node_count       (node_count),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .flow_value       (flow_value),
        .status           (status)
    );

    always #6 clk = ~clk;

    // Watchdog; also throttles the result side (~31% stall outside steady stretches).
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 31);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL max_flow_isap_engine_top");
            $finish;
        end
    end

    // Monitors: values seen at the edge are the pre-edge ones.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_command(op, from_node, to_node, capacity, reverse_capacity,
                            source_node, sink_node, node_count);
        if (rst_n && out_valid && out_ready)
            sb.check_result(flow_value, status);
    end

    function logic [CAP_W-1:0] rnd_cap();
        return CAP_W'($urandom());
    endfunction

    function logic [CAP_W-1:0] pick_cap();
        case ($urandom_range(9))
            0: return '0;
            1: return {CAP_W{1'b1}};
            2: return rnd_cap();
            default: return CAP_W'($urandom_range(40));
        endcase
    endfunction

    // One command transaction; node fields passed as negative values are randomized.
    task automatic send(input logic [1:0] o, input int f, input int t,
                        input logic [CAP_W-1:0] c, input logic [CAP_W-1:0] rc,
                        input int s, input int k, input int n);
        if (!steady && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        op               <= o;
        from_node        <= (f < 0) ? 10'($urandom()) : 10'(f);
        to_node          <= (t < 0) ? 10'($urandom()) : 10'(t);
        capacity         <= c;
        reverse_capacity <= rc;
        source_node      <= (s < 0) ? 10'($urandom()) : 10'(s);
        sink_node        <= (k < 0) ? 10'($urandom()) : 10'(k);
        node_count       <= (n < 0) ? 11'($urandom()) : 11'(n);
        in_valid         <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic add(input int f, input int t, input logic [CAP_W-1:0] c,
                       input logic [CAP_W-1:0] rc);
        send(OP_ADD, f, t, c, rc, -1, -1, -1);
    endtask

    task automatic run(input int s, input int k, input int n);
        send(OP_RUN, -1, -1, rnd_cap(), rnd_cap(), s, k, n);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    initial
    begin
        int nn, ne;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: op coverage, rejected runs, extremes, saturation ---
        steady = 1'b1;
        send(OP_CLEAR, -1, -1, rnd_cap(), rnd_cap(), -1, -1, -1);
        send(OP_SPARE, -1, -1, rnd_cap(), rnd_cap(), -1, -1, -1);
        run(0, 1, 0);                       // empty node count
        run(0, 1, 2047);                    // node count past the limit
        run(3, 3, 8);                       // source equals sink
        run(9, 1, 8);                       // source outside node count
        run(1, 8, 8);                       // sink outside node count
        add(1023, 0, {CAP_W{1'b1}}, {CAP_W{1'b1}});
        run(1023, 0, 1024);
        run(0, 1023, 1024);                 // continues from the stored flow
        send(OP_CLEAR, -1, -1, '0, '0, -1, -1, -1);
        repeat (5) add(0, 1, {CAP_W{1'b1}}, '0);
        run(0, 1, 2);                       // total saturates at 32 bits
        run(0, 1, 2);
        add(0, 5, CAP_W'(7), '0);           // detour through a node beyond n
        add(5, 1, CAP_W'(9), CAP_W'(3));
        run(1, 0, 2);
        run(0, 1, 2);
        add(2, 3, '0, '0);
        run(2, 3, 4);                       // no path: gap cut-off
        steady = 1'b0;

        // --- long burst of edge loads ---
        send(OP_CLEAR, -1, -1, '0, '0, -1, -1, -1);
        for (int i = 0; i < 300; i++) add(-1, -1, rnd_cap(), rnd_cap());
        wait_drained();
        send(OP_CLEAR, -1, -1, '0, '0, -1, -1, -1);

        // --- random graphs: clear, build, run a few times, plus noise ---
        for (int g = 0; g < 150; g++)
        begin
            steady = (g >= 40 && g < 55);
            if (g == 70) wait_drained();
            send(OP_CLEAR, -1, -1, rnd_cap(), rnd_cap(), -1, -1, -1);
            nn = $urandom_range(2, 9);
            ne = $urandom_range(1, 14);
            for (int i = 0; i < ne; i++)
            begin
                if ($urandom_range(19) == 0)
                    add(-1, -1, pick_cap(), pick_cap());    // far-away nodes
                else
                    add($urandom_range(nn - 1), $urandom_range(nn - 1), pick_cap(),
                        ($urandom_range(2) == 0) ? pick_cap() : '0);
            end
            repeat ($urandom_range(1, 3))
            begin
                int s, k;
                s = $urandom_range(nn - 1);
                k = $urandom_range(nn - 1);
                if (s == k) k = (s + 1) % nn;
                case ($urandom_range(9))
                    0: run(-1, -1, -1);                     // mostly rejected
                    1: send(OP_SPARE, -1, -1, rnd_cap(), rnd_cap(), -1, -1, -1);
                    2: run(s, k, nn + $urandom_range(3));
                    default: run(s, k, nn);
                endcase
            end
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS max_flow_isap_engine_top");
        else
            $display("FAIL max_flow_isap_engine_top");
        $finish;
    end

endmodule
